FILE: rtl/rgbab_pkg.sv
`default_nettype none

package rgbab_pkg;

	// Default sizes of the two stores.
	localparam int FB_MAX_W_DEF     = 512;
	localparam int FB_MAX_H_DEF     = 512;
	localparam int TEX_MAX_SIZE_DEF = 256;

	// Signed width of all internal coordinate arithmetic.
	localparam int COORD_W = 14;

	// Number of quotient bits produced by the step divider.
	localparam int DIV_STEPS = 11;

	// Register reset values.
	localparam logic [9:0] FB_WIDTH_RST   = 10'd512;
	localparam logic [9:0] FB_HEIGHT_RST  = 10'd512;
	localparam logic [8:0] TEX_WIDTH_RST  = 9'd256;
	localparam logic [8:0] TEX_HEIGHT_RST = 9'd256;

	// Configuration register indexes.
	localparam logic [2:0] REG_FB_WIDTH   = 3'd0;
	localparam logic [2:0] REG_FB_HEIGHT  = 3'd1;
	localparam logic [2:0] REG_TEX_WIDTH  = 3'd2;
	localparam logic [2:0] REG_TEX_HEIGHT = 3'd3;

	// Command codes.
	localparam logic [2:0] MODE_CLEAR = 3'd0;
	localparam logic [2:0] MODE_FILL  = 3'd1;
	localparam logic [2:0] MODE_DRAW  = 3'd2;
	localparam logic [2:0] MODE_LOAD  = 3'd3;
	localparam logic [2:0] MODE_READ  = 3'd4;

	localparam logic STATUS_DONE  = 1'b0;
	localparam logic STATUS_EMPTY = 1'b1;

	typedef enum logic [3:0] {
		ST_TCLR,
		ST_IDLE,
		ST_SETUP,
		ST_DIV,
		ST_CLEAR,
		ST_ROW,
		ST_PIX,
		ST_READ,
		ST_DRAIN,
		ST_RESP
	} state_t;

	// Floor division by 255, exact for every value up to 255 * 255.
	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [16:0] t;
		t = 17'(x) + 17'd1 + 17'(x[15:8]);
		return t[15:8];
	endfunction

	// Blend one colour over another with weight a/255; stored alpha becomes 255.
	function automatic logic [31:0] blend(input logic [31:0] src, input logic [31:0] dst,
			input logic [7:0] a);
		logic [31:0] res;
		logic [15:0] acc;
		res = 32'hFF00_0000;
		if (a == 8'hFF) begin
			res[23:0] = src[23:0];
		end else begin
			for (int k = 0; k < 3; k++) begin
				acc = 16'(src[8*k +: 8]) * 16'(a) + 16'(dst[8*k +: 8]) * 16'(8'hFF - a);
				res[8*k +: 8] = div255(acc);
			end
		end
		return res;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/rgba_blitter_fill_blend_top.sv
`default_nettype none

// RGBA8 blitter with an on-chip framebuffer and texture store. One command is taken at a time
// and gives one result transfer. After reset the texture store is cleared, one texel a cycle;
// no command is taken meanwhile. Clear writes fb_width*fb_height pixels, one framebuffer
// write port doing one pixel a cycle. Fill and draw set up, walk the iterated rectangle row
// by row and drain; draw runs the scaling step divider before the walk. Load writes its
// texel in setup; read issues its framebuffer read in setup and takes the data in the read
// state. Pixels are blended through a read, blend and write pipeline on the framebuffer
// memory; it drains before each result.
module rgba_blitter_fill_blend_top #(
	parameter int FB_MAX_W     = rgbab_pkg::FB_MAX_W_DEF,
	parameter int FB_MAX_H     = rgbab_pkg::FB_MAX_H_DEF,
	parameter int TEX_MAX_SIZE = rgbab_pkg::TEX_MAX_SIZE_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// dest_x, dest_y, dest_w, dest_h, src_x, src_y, src_w, src_h, pixel_value, tint_alpha
	input  wire logic [135:0] s_tdata,
	// mode, whole_source
	input  wire logic [3:0]   s_tuser,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// read_data
	output logic [31:0]       m_tdata,
	// status
	output logic [0:0]        m_tuser,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [2:0]   cfg_index,
	input  wire logic [9:0]   cfg_data
);

	localparam int CW        = rgbab_pkg::COORD_W;
	localparam int FB_DEPTH  = FB_MAX_W * FB_MAX_H;
	localparam int FB_AW     = $clog2(FB_DEPTH);
	localparam int TEX_DEPTH = TEX_MAX_SIZE * TEX_MAX_SIZE;
	localparam int TEX_AW    = $clog2(TEX_DEPTH);

	rgbab_pkg::state_t state_q, state_d;

	// Configuration registers and their clamped sizes.
	logic [9:0] fb_width_q, fb_height_q, fw, fh;
	logic [8:0] tex_width_q, tex_height_q, tw, th;

	// Command registers.
	logic [2:0]           mode_q;
	logic signed [CW-1:0] dx_q, dy_q, dw_q, dh_q, sx0_q, sy0_q, sw_q, sh_q;
	logic [31:0]          pix_q;
	logic [7:0]           tint_q;

	// Loop registers.
	logic signed [CW-1:0] bx_q, by_q;
	logic [10:0]          xn_q, yn_q, xi_q, yi_q, qx_q, qy_q, rx_q, ry_q;
	logic [FB_AW-1:0]     fb_row_q, clr_cnt_q, clr_last_q;
	logic [TEX_AW-1:0]    tex_row_q, tclr_cnt_q;
	logic [3:0]           div_cnt_q;
	logic [10:0]          dnx_q, dny_q, rmx_q, rmy_q, stx_q, sty_q;

	// Result registers.
	logic [31:0] res_data_q;
	logic        res_status_q;
	logic        m_tvalid_q;
	logic [31:0] m_tdata_q;
	logic        m_tuser_q;

	// Memories and their ports.
	logic [31:0]       fb_mem [FB_DEPTH];
	logic [31:0]       tex_mem [TEX_DEPTH];
	logic [31:0]       fb_rd_q, tex_rd_q, fb_wdata, tex_wdata;
	logic [FB_AW-1:0]  fb_raddr, fb_waddr;
	logic [TEX_AW-1:0] tex_raddr, tex_waddr;
	logic              fb_re, fb_we, tex_re, tex_we;

	// Pixel pipeline.
	logic             v_s1, v_s2;
	logic [FB_AW-1:0] addr_s1, addr_s2;
	logic [31:0]      src_s2, dst_s2;
	logic [7:0]       a_s2;

	// Combinational helpers.
	logic signed [CW-1:0] fw_s, fh_s, tw_s, th_s;
	logic signed [CW-1:0] x0, y0, x1, y1, ty, sy, tx, sx;
	logic                 fill_empty, draw_empty, load_in, read_in, is_draw, is_fill;
	logic                 row_ok, pix_ok, last_row, last_col, row_adv, pix_issue;
	logic [22:0]          fb_row_prod, rd_prod;
	logic [21:0]          tex_row_prod, ld_prod;
	logic [19:0]          area;
	logic [11:0]          rxs, rys, dtx, dty;
	logic                 cx, cy;
	logic [10:0]          rx_n, ry_n, qx_n, qy_n;
	logic [11:0]          dtrx, dtry;
	logic                 dgx, dgy;
	logic [31:0]          src_c;
	logic [15:0]          tint_p;
	logic [7:0]           a_raw, a_c;

	// Clamp the register sizes into their usable ranges.
	always_comb begin
		fw = (fb_width_q == '0) ? 10'd1 :
			((32'(fb_width_q) > FB_MAX_W) ? 10'(FB_MAX_W) : fb_width_q);
		fh = (fb_height_q == '0) ? 10'd1 :
			((32'(fb_height_q) > FB_MAX_H) ? 10'(FB_MAX_H) : fb_height_q);
		tw = (tex_width_q == '0) ? 9'd1 :
			((32'(tex_width_q) > TEX_MAX_SIZE) ? 9'(TEX_MAX_SIZE) : tex_width_q);
		th = (tex_height_q == '0) ? 9'd1 :
			((32'(tex_height_q) > TEX_MAX_SIZE) ? 9'(TEX_MAX_SIZE) : tex_height_q);
		fw_s = $signed({4'b0, fw});
		fh_s = $signed({4'b0, fh});
		tw_s = $signed({5'b0, tw});
		th_s = $signed({5'b0, th});
	end

	// Command decode and range checks, used while in setup.
	always_comb begin
		is_draw    = (mode_q == rgbab_pkg::MODE_DRAW);
		is_fill    = (mode_q == rgbab_pkg::MODE_FILL);
		x0         = (dx_q < 0) ? '0 : dx_q;
		y0         = (dy_q < 0) ? '0 : dy_q;
		x1         = (dx_q + dw_q > fw_s) ? fw_s : dx_q + dw_q;
		y1         = (dy_q + dh_q > fh_s) ? fh_s : dy_q + dh_q;
		fill_empty = !((x0 < x1) && (y0 < y1));
		draw_empty = (dw_q <= 0) || (dh_q <= 0);
		load_in    = (dx_q >= 0) && (dx_q < tw_s) && (dy_q >= 0) && (dy_q < th_s);
		read_in    = (dx_q >= 0) && (dx_q < fw_s) && (dy_q >= 0) && (dy_q < fh_s);
		ld_prod    = 22'(dy_q[12:0]) * 22'(tw);
		rd_prod    = 23'(dy_q[12:0]) * 23'(fw);
		area       = 20'(fw) * 20'(fh);
	end

	// Row and pixel positions with their nearest-neighbour source coordinates.
	always_comb begin
		ty           = by_q + $signed({3'b0, yi_q});
		sy           = (sh_q > 0) ? sy0_q + $signed({3'b0, qy_q}) : '0;
		row_ok       = is_fill || ((sy >= 0) && (sy < th_s) && (ty >= 0) && (ty < fh_s));
		fb_row_prod  = 23'(ty[12:0]) * 23'(fw);
		tex_row_prod = 22'(sy[12:0]) * 22'(tw);
		tx           = bx_q + $signed({3'b0, xi_q});
		sx           = (sw_q > 0) ? sx0_q + $signed({3'b0, qx_q}) : '0;
		pix_ok       = is_fill || ((sx >= 0) && (sx < tw_s) && (tx >= 0) && (tx < fw_s));
		last_row     = (yi_q == yn_q - 11'd1);
		last_col     = (xi_q == xn_q - 11'd1);
		// Step the scaled source position by quotient and remainder.
		rxs  = {1'b0, rx_q} + {1'b0, rmx_q};
		dtx  = {1'b0, dw_q[10:0]};
		cx   = (rxs >= dtx);
		rx_n = cx ? 11'(rxs - dtx) : rxs[10:0];
		qx_n = 11'({1'b0, qx_q} + {1'b0, stx_q} + 12'(cx));
		rys  = {1'b0, ry_q} + {1'b0, rmy_q};
		dty  = {1'b0, dh_q[10:0]};
		cy   = (rys >= dty);
		ry_n = cy ? 11'(rys - dty) : rys[10:0];
		qy_n = 11'({1'b0, qy_q} + {1'b0, sty_q} + 12'(cy));
		// One restoring division step in each lane.
		dtrx = {rmx_q, dnx_q[10]};
		dgx  = (dtrx >= {1'b0, dw_q[10:0]});
		dtry = {rmy_q, dny_q[10]};
		dgy  = (dtry >= {1'b0, dh_q[10:0]});
	end

	// Next state and memory port control.
	always_comb begin
		state_d   = state_q;
		row_adv   = 1'b0;
		pix_issue = 1'b0;
		fb_re     = 1'b0;
		fb_raddr  = fb_row_q + FB_AW'($unsigned(tx));
		tex_re    = 1'b0;
		tex_raddr = tex_row_q + TEX_AW'($unsigned(sx));
		tex_we    = 1'b0;
		tex_waddr = tclr_cnt_q;
		tex_wdata = '0;
		fb_we     = v_s2;
		fb_waddr  = addr_s2;
		fb_wdata  = rgbab_pkg::blend(src_s2, dst_s2, a_s2);
		case (state_q)
			rgbab_pkg::ST_TCLR: begin
				tex_we = 1'b1;
				if (tclr_cnt_q == TEX_AW'(TEX_DEPTH - 1)) state_d = rgbab_pkg::ST_IDLE;
			end
			rgbab_pkg::ST_IDLE: begin
				if (s_tvalid) state_d = rgbab_pkg::ST_SETUP;
			end
			rgbab_pkg::ST_SETUP: begin
				case (mode_q)
					rgbab_pkg::MODE_CLEAR: state_d = rgbab_pkg::ST_CLEAR;
					rgbab_pkg::MODE_FILL: begin
						state_d = (fill_empty || pix_q[31:24] == 8'h00) ?
							rgbab_pkg::ST_RESP : rgbab_pkg::ST_ROW;
					end
					rgbab_pkg::MODE_DRAW: begin
						state_d = draw_empty ? rgbab_pkg::ST_RESP : rgbab_pkg::ST_DIV;
					end
					rgbab_pkg::MODE_LOAD: begin
						tex_we    = load_in;
						tex_waddr = TEX_AW'(ld_prod) + TEX_AW'($unsigned(dx_q));
						tex_wdata = pix_q;
						state_d   = rgbab_pkg::ST_RESP;
					end
					rgbab_pkg::MODE_READ: begin
						fb_re    = read_in;
						fb_raddr = FB_AW'(rd_prod) + FB_AW'($unsigned(dx_q));
						state_d  = read_in ? rgbab_pkg::ST_READ : rgbab_pkg::ST_RESP;
					end
					default: state_d = rgbab_pkg::ST_RESP;
				endcase
			end
			rgbab_pkg::ST_DIV: begin
				if (div_cnt_q == 4'(rgbab_pkg::DIV_STEPS - 1)) state_d = rgbab_pkg::ST_ROW;
			end
			rgbab_pkg::ST_CLEAR: begin
				fb_we    = 1'b1;
				fb_waddr = clr_cnt_q;
				fb_wdata = pix_q;
				if (clr_cnt_q == clr_last_q) state_d = rgbab_pkg::ST_RESP;
			end
			rgbab_pkg::ST_ROW: begin
				if (row_ok) begin
					state_d = rgbab_pkg::ST_PIX;
				end else begin
					row_adv = 1'b1;
					if (last_row) state_d = rgbab_pkg::ST_DRAIN;
				end
			end
			rgbab_pkg::ST_PIX: begin
				pix_issue = pix_ok;
				fb_re     = pix_ok;
				tex_re    = pix_ok && is_draw;
				if (last_col) begin
					row_adv = 1'b1;
					state_d = last_row ? rgbab_pkg::ST_DRAIN : rgbab_pkg::ST_ROW;
				end
			end
			rgbab_pkg::ST_READ: state_d = rgbab_pkg::ST_RESP;
			rgbab_pkg::ST_DRAIN: begin
				if (!v_s1 && !v_s2) state_d = rgbab_pkg::ST_RESP;
			end
			rgbab_pkg::ST_RESP: begin
				if (!m_tvalid_q || m_tready) state_d = rgbab_pkg::ST_IDLE;
			end
			default: state_d = rgbab_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rgbab_pkg::ST_TCLR;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fb_width_q   <= rgbab_pkg::FB_WIDTH_RST;
			fb_height_q  <= rgbab_pkg::FB_HEIGHT_RST;
			tex_width_q  <= rgbab_pkg::TEX_WIDTH_RST;
			tex_height_q <= rgbab_pkg::TEX_HEIGHT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				rgbab_pkg::REG_FB_WIDTH:   fb_width_q   <= cfg_data;
				rgbab_pkg::REG_FB_HEIGHT:  fb_height_q  <= cfg_data;
				rgbab_pkg::REG_TEX_WIDTH:  tex_width_q  <= cfg_data[8:0];
				rgbab_pkg::REG_TEX_HEIGHT: tex_height_q <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	// Capture a command; a whole-texture draw takes the texture as its source.
	always_ff @(posedge clk) begin
		if (state_q == rgbab_pkg::ST_IDLE && s_tvalid) begin
			mode_q <= s_tuser[2:0];
			dx_q   <= CW'($signed(s_tdata[11:0]));
			dy_q   <= CW'($signed(s_tdata[23:12]));
			dw_q   <= CW'($signed(s_tdata[35:24]));
			dh_q   <= CW'($signed(s_tdata[47:36]));
			pix_q  <= s_tdata[127:96];
			tint_q <= s_tdata[135:128];
			if (s_tuser[3]) begin
				sx0_q <= '0;
				sy0_q <= '0;
				sw_q  <= tw_s;
				sh_q  <= th_s;
			end else begin
				sx0_q <= CW'($signed(s_tdata[59:48]));
				sy0_q <= CW'($signed(s_tdata[71:60]));
				sw_q  <= CW'($signed(s_tdata[83:72]));
				sh_q  <= CW'($signed(s_tdata[95:84]));
			end
		end
	end

	// Sweep counters, divider and rectangle walk.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tclr_cnt_q <= '0;
			clr_cnt_q  <= '0;
			div_cnt_q  <= '0;
			xi_q       <= '0;
			yi_q       <= '0;
		end else begin
			if (state_q == rgbab_pkg::ST_TCLR) tclr_cnt_q <= tclr_cnt_q + 1'b1;
			if (state_q == rgbab_pkg::ST_SETUP) begin
				clr_cnt_q <= '0;
				div_cnt_q <= '0;
				yi_q      <= '0;
				xi_q      <= '0;
			end
			if (state_q == rgbab_pkg::ST_CLEAR) clr_cnt_q <= clr_cnt_q + 1'b1;
			if (state_q == rgbab_pkg::ST_DIV) div_cnt_q <= div_cnt_q + 1'b1;
			if (row_adv) begin
				yi_q <= yi_q + 11'd1;
				xi_q <= '0;
			end else if (state_q == rgbab_pkg::ST_PIX) begin
				xi_q <= xi_q + 11'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == rgbab_pkg::ST_SETUP) begin
			clr_last_q <= FB_AW'(area - 20'd1);
			dnx_q      <= sw_q[10:0];
			dny_q      <= sh_q[10:0];
			rmx_q      <= '0;
			rmy_q      <= '0;
			qy_q       <= '0;
			ry_q       <= '0;
			qx_q       <= '0;
			rx_q       <= '0;
			if (is_fill) begin
				bx_q <= x0;
				by_q <= y0;
				xn_q <= 11'(x1 - x0);
				yn_q <= 11'(y1 - y0);
			end else begin
				bx_q <= dx_q;
				by_q <= dy_q;
				xn_q <= dw_q[10:0];
				yn_q <= dh_q[10:0];
			end
		end
		if (state_q == rgbab_pkg::ST_DIV) begin
			dnx_q <= {dnx_q[9:0], 1'b0};
			dny_q <= {dny_q[9:0], 1'b0};
			stx_q <= {stx_q[9:0], dgx};
			sty_q <= {sty_q[9:0], dgy};
			rmx_q <= dgx ? 11'(dtrx - {1'b0, dw_q[10:0]}) : dtrx[10:0];
			rmy_q <= dgy ? 11'(dtry - {1'b0, dh_q[10:0]}) : dtry[10:0];
		end
		if (state_q == rgbab_pkg::ST_ROW) begin
			fb_row_q  <= FB_AW'(fb_row_prod);
			tex_row_q <= TEX_AW'(tex_row_prod);
			qx_q      <= '0;
			rx_q      <= '0;
		end
		if (state_q == rgbab_pkg::ST_PIX) begin
			qx_q <= qx_n;
			rx_q <= rx_n;
		end
		if (row_adv) begin
			qy_q <= qy_n;
			ry_q <= ry_n;
		end
	end

	// Result of the command.
	always_ff @(posedge clk) begin
		if (state_q == rgbab_pkg::ST_SETUP) begin
			res_data_q <= '0;
			case (mode_q)
				rgbab_pkg::MODE_CLEAR: res_status_q <= rgbab_pkg::STATUS_DONE;
				rgbab_pkg::MODE_FILL: begin
					res_status_q <= fill_empty ? rgbab_pkg::STATUS_EMPTY : rgbab_pkg::STATUS_DONE;
				end
				rgbab_pkg::MODE_LOAD: begin
					res_status_q <= load_in ? rgbab_pkg::STATUS_DONE : rgbab_pkg::STATUS_EMPTY;
				end
				default: res_status_q <= rgbab_pkg::STATUS_EMPTY;
			endcase
		end
		if (state_q == rgbab_pkg::ST_READ) begin
			res_data_q   <= fb_rd_q;
			res_status_q <= rgbab_pkg::STATUS_DONE;
		end
		if (pix_issue) res_status_q <= rgbab_pkg::STATUS_DONE;
	end

	// Output register for the result transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == rgbab_pkg::ST_RESP && (!m_tvalid_q || m_tready)) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == rgbab_pkg::ST_RESP && (!m_tvalid_q || m_tready)) begin
			m_tdata_q <= res_data_q;
			m_tuser_q <= res_status_q;
		end
	end

	// Framebuffer and texture memories, one read and one write port each.
	always_ff @(posedge clk) begin
		if (fb_re) fb_rd_q <= fb_mem[fb_raddr];
		if (fb_we) fb_mem[fb_waddr] <= fb_wdata;
	end

	always_ff @(posedge clk) begin
		if (tex_re) tex_rd_q <= tex_mem[tex_raddr];
		if (tex_we) tex_mem[tex_waddr] <= tex_wdata;
	end

	// Stage one: the source alpha, scaled by the tint for a draw.
	always_comb begin
		src_c  = is_draw ? tex_rd_q : pix_q;
		a_raw  = src_c[31:24];
		tint_p = 16'(a_raw) * 16'(tint_q);
		a_c    = (is_draw && tint_q != 8'hFF) ? rgbab_pkg::div255(tint_p) : a_raw;
	end

	// Destination pixels within one command are distinct, so the read, blend and
	// write stages never overlap on an entry; the pipe drains before each result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= pix_issue;
			v_s2 <= v_s1 && (a_c != 8'h00);
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= fb_raddr;
		addr_s2 <= addr_s1;
		src_s2  <= src_c;
		dst_s2  <= fb_rd_q;
		a_s2    <= a_c;
	end

	assign s_tready  = (state_q == rgbab_pkg::ST_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;
	assign m_tuser   = m_tuser_q;

`ifndef SYNTHESIS
	a_accept_pipe_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |-> (!v_s1 && !v_s2))
		else $error("command taken while pixel pipe busy");
	a_clear_no_blend: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rgbab_pkg::ST_CLEAR) |-> !v_s2)
		else $error("blend write during clear sweep");
	a_s2_follows_s1: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> $past(v_s1))
		else $error("blend stage valid without a read stage");
	a_no_result_in_tclr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rgbab_pkg::ST_TCLR) |-> !m_tvalid)
		else $error("result during texture clear");
`endif

endmodule

`default_nettype wire

FILE: bench/rgba_blitter_fill_blend_top_tb.sv
`default_nettype none

module rgba_blitter_fill_blend_top_tb;

	localparam int FW_MAX = 512;
	localparam int FH_MAX = 512;
	localparam int TEX_MAX = 256;

	typedef struct {
		logic [2:0]         mode;
		logic signed [11:0] dest_x, dest_y, dest_w, dest_h;
		logic signed [11:0] src_x, src_y, src_w, src_h;
		logic               whole_source;
		logic [31:0]        pixel_value;
		logic [7:0]         tint_alpha;
	} blit_cmd_t;

	typedef struct {
		logic [31:0] read_data;
		logic        status;
	} blit_resp_t;

	logic         clk;
	logic         arst_n;
	logic [135:0] s_tdata;
	logic [3:0]   s_tuser;
	logic         s_tvalid;
	logic         s_tready;
	logic [31:0]  m_tdata;
	logic [0:0]   m_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [2:0]   cfg_index;
	logic [9:0]   cfg_data;

	rgba_blitter_fill_blend_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tdata(s_tdata), .s_tuser(s_tuser), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.m_tdata(m_tdata), .m_tuser(m_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Shadow copies of the block's stores and registers.
	logic [31:0] frame_mem [0:FW_MAX*FH_MAX-1];
	logic [31:0] texel_mem [0:TEX_MAX*TEX_MAX-1];
	logic [9:0]  reg_fb_w, reg_fb_h;
	logic [8:0]  reg_tex_w, reg_tex_h;

	blit_cmd_t  cur_cmd;
	blit_resp_t pending_resp [$];
	int         sent_cnt;
	int         got_cnt;
	int         mismatch_cnt;
	bit         hold_rx;
	bit         rx_done;

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	assign s_tdata = {cur_cmd.tint_alpha, cur_cmd.pixel_value, cur_cmd.src_h, cur_cmd.src_w,
		cur_cmd.src_y, cur_cmd.src_x, cur_cmd.dest_h, cur_cmd.dest_w, cur_cmd.dest_y,
		cur_cmd.dest_x};
	assign s_tuser = {cur_cmd.whole_source, cur_cmd.mode};

	function automatic int eff_size(input int v, input int vmax);
		if (v == 0) return 1;
		if (v > vmax) return vmax;
		return v;
	endfunction

	// Weighted mix of two colours; written pixels always get alpha 255.
	function automatic logic [31:0] mix_pixel(input logic [31:0] fg, input logic [31:0] bg,
			input int a);
		logic [31:0] r;
		int          s, d;
		r = 32'hFF00_0000;
		for (int k = 0; k < 3; k++) begin
			s = fg[8*k +: 8];
			d = bg[8*k +: 8];
			r[8*k +: 8] = (a == 255) ? fg[8*k +: 8] : 8'((s * a + d * (255 - a)) / 255);
		end
		return r;
	endfunction

	// Applies one command to the shadow stores and returns the result it gives.
	function automatic blit_resp_t apply_blit(input blit_cmd_t c);
		blit_resp_t r;
		int fw, fh, tw, th, dx, dy, dw, dh, sx0, sy0, sw, sh;
		int x0, y0, x1, y1, a, sx, sy, tx, ty, idx;
		logic [31:0] texel;
		fw = eff_size(reg_fb_w, FW_MAX);
		fh = eff_size(reg_fb_h, FH_MAX);
		tw = eff_size(reg_tex_w, TEX_MAX);
		th = eff_size(reg_tex_h, TEX_MAX);
		dx = c.dest_x; dy = c.dest_y; dw = c.dest_w; dh = c.dest_h;
		sx0 = c.src_x; sy0 = c.src_y; sw = c.src_w; sh = c.src_h;
		r.read_data = '0;
		r.status = rgbab_pkg::STATUS_EMPTY;
		case (c.mode)
			rgbab_pkg::MODE_CLEAR: begin
				for (int i = 0; i < fw * fh; i++) frame_mem[i] = c.pixel_value;
				r.status = rgbab_pkg::STATUS_DONE;
			end
			rgbab_pkg::MODE_FILL: begin
				x0 = dx < 0 ? 0 : dx;
				y0 = dy < 0 ? 0 : dy;
				x1 = dx + dw > fw ? fw : dx + dw;
				y1 = dy + dh > fh ? fh : dy + dh;
				a = c.pixel_value[31:24];
				if (x0 < x1 && y0 < y1) begin
					r.status = rgbab_pkg::STATUS_DONE;
					if (a != 0) begin
						for (int y = y0; y < y1; y++)
							for (int x = x0; x < x1; x++) begin
								idx = y * fw + x;
								frame_mem[idx] = mix_pixel(c.pixel_value, frame_mem[idx], a);
							end
					end
				end
			end
			rgbab_pkg::MODE_DRAW: begin
				if (c.whole_source) begin
					sx0 = 0; sy0 = 0; sw = tw; sh = th;
				end
				if (dw > 0 && dh > 0) begin
					for (int y = 0; y < dh; y++) begin
						ty = dy + y;
						sy = sh > 0 ? sy0 + (y * sh) / dh : 0;
						if (sy < 0 || sy >= th || ty < 0 || ty >= fh) continue;
						for (int x = 0; x < dw; x++) begin
							tx = dx + x;
							sx = sw > 0 ? sx0 + (x * sw) / dw : 0;
							if (sx < 0 || sx >= tw || tx < 0 || tx >= fw) continue;
							texel = texel_mem[sy * tw + sx];
							a = texel[31:24];
							if (c.tint_alpha != 8'hFF) a = (a * c.tint_alpha) / 255;
							r.status = rgbab_pkg::STATUS_DONE;
							if (a == 0) continue;
							idx = ty * fw + tx;
							frame_mem[idx] = mix_pixel(texel, frame_mem[idx], a);
						end
					end
				end
			end
			rgbab_pkg::MODE_LOAD: begin
				if (dx >= 0 && dx < tw && dy >= 0 && dy < th) begin
					texel_mem[dy * tw + dx] = c.pixel_value;
					r.status = rgbab_pkg::STATUS_DONE;
				end
			end
			rgbab_pkg::MODE_READ: begin
				if (dx >= 0 && dx < fw && dy >= 0 && dy < fh) begin
					r.read_data = frame_mem[dy * fw + dx];
					r.status = rgbab_pkg::STATUS_DONE;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// Accepted commands are predicted; result transfers are checked in order.
	always @(posedge clk) begin
		blit_resp_t want;
		if (arst_n && s_tvalid && s_tready) pending_resp.push_back(apply_blit(cur_cmd));
		if (arst_n && m_tvalid && m_tready) begin
			got_cnt++;
			rx_done = 1'b1;
			if (pending_resp.size() == 0) begin
				mismatch_cnt++;
				if (mismatch_cnt <= 10) $display("unexpected result data=%h status=%b",
					m_tdata, m_tuser);
			end else begin
				want = pending_resp.pop_front();
				if (m_tdata !== want.read_data || m_tuser[0] !== want.status) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10)
						$display("result mismatch: expected data=%h status=%b, got %h %b",
							want.read_data, want.status, m_tdata, m_tuser);
				end
			end
		end
	end

	// Result receiver with random stalls and an optional long hold-off.
	initial begin
		int stall;
		stall = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_done) begin
				rx_done = 1'b0;
				stall = $urandom_range(0, 1) ? 0 : $urandom_range(0, 7);
			end
			if (hold_rx) begin
				m_tready = 1'b0;
			end else if (stall > 0) begin
				m_tready = 1'b0;
				stall--;
			end else begin
				m_tready = 1'b1;
			end
		end
	end

	function automatic blit_cmd_t make_cmd(input logic [2:0] mode, input int dx, input int dy,
			input int dw, input int dh, input logic [31:0] pix);
		blit_cmd_t c;
		c.mode = mode;
		c.dest_x = 12'(dx); c.dest_y = 12'(dy); c.dest_w = 12'(dw); c.dest_h = 12'(dh);
		c.src_x = '0; c.src_y = '0; c.src_w = '0; c.src_h = '0;
		c.whole_source = 1'b0;
		c.pixel_value = pix;
		c.tint_alpha = 8'hFF;
		return c;
	endfunction

	function automatic blit_cmd_t make_draw(input int dx, input int dy, input int dw,
			input int dh, input int sx, input int sy, input int sw, input int sh,
			input logic whole, input logic [7:0] tint);
		blit_cmd_t c;
		c = make_cmd(rgbab_pkg::MODE_DRAW, dx, dy, dw, dh, $urandom);
		c.src_x = 12'(sx); c.src_y = 12'(sy); c.src_w = 12'(sw); c.src_h = 12'(sh);
		c.whole_source = whole;
		c.tint_alpha = tint;
		return c;
	endfunction

	// Sends one command; valid stays high when the next one follows without a gap.
	task automatic send_cmd(input blit_cmd_t c);
		int gap;
		gap = $urandom_range(0, 1) ? 0 : $urandom_range(0, 7);
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		cur_cmd = c;
		s_tvalid = 1'b1;
		sent_cnt++;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		s_tvalid = 1'b0;
		wait (got_cnt == sent_cnt);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [9:0] val);
		wait_idle();
		@(negedge clk);
		cfg_index = idx;
		cfg_data = val;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			rgbab_pkg::REG_FB_WIDTH:   reg_fb_w = val;
			rgbab_pkg::REG_FB_HEIGHT:  reg_fb_h = val;
			rgbab_pkg::REG_TEX_WIDTH:  reg_tex_w = val[8:0];
			rgbab_pkg::REG_TEX_HEIGHT: reg_tex_h = val[8:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// A frame size change is always followed by a clear, so no pixel is read unwritten.
	task automatic set_sizes(input int fw, input int fh, input int tw, input int th);
		write_reg(rgbab_pkg::REG_FB_WIDTH, 10'(fw));
		write_reg(rgbab_pkg::REG_FB_HEIGHT, 10'(fh));
		write_reg(rgbab_pkg::REG_TEX_WIDTH, 10'(tw));
		write_reg(rgbab_pkg::REG_TEX_HEIGHT, 10'(th));
		send_cmd(make_cmd(rgbab_pkg::MODE_CLEAR, 0, 0, 0, 0, $urandom));
	endtask

	task automatic test_fill_and_read();
		send_cmd(make_cmd(rgbab_pkg::MODE_FILL, 2, 3, 5, 4, 32'h80_10_20_30));
		send_cmd(make_cmd(rgbab_pkg::MODE_FILL, -3, -2, 6, 5, 32'hFF_AA_55_01));
		send_cmd(make_cmd(rgbab_pkg::MODE_FILL, 10, 8, 20, 20, 32'h00_12_34_56));
		send_cmd(make_cmd(rgbab_pkg::MODE_FILL, 4, 4, 0, 3, 32'hFF_FF_FF_FF));
		send_cmd(make_cmd(rgbab_pkg::MODE_FILL, 4, 4, -1, -1, 32'h40_00_00_00));
		send_cmd(make_cmd(rgbab_pkg::MODE_FILL, 16, 0, 3, 3, 32'hFF_00_00_00));
		send_cmd(make_cmd(rgbab_pkg::MODE_READ, 3, 4, 0, 0, 0));
		send_cmd(make_cmd(rgbab_pkg::MODE_READ, 0, 0, 0, 0, 0));
		send_cmd(make_cmd(rgbab_pkg::MODE_READ, 15, 11, 0, 0, 0));
		send_cmd(make_cmd(rgbab_pkg::MODE_READ, 16, 0, 0, 0, 0));
		send_cmd(make_cmd(rgbab_pkg::MODE_READ, -1, 2047, 0, 0, 0));
		send_cmd(make_cmd(rgbab_pkg::MODE_READ, -2048, 0, 0, 0, 0));
	endtask

	task automatic test_texture_draw();
		send_cmd(make_cmd(rgbab_pkg::MODE_LOAD, 0, 0, 0, 0, 32'hFF_11_22_33));
		send_cmd(make_cmd(rgbab_pkg::MODE_LOAD, 7, 7, 0, 0, 32'h7F_C0_80_40));
		send_cmd(make_cmd(rgbab_pkg::MODE_LOAD, 3, 2, 0, 0, 32'h00_FF_FF_FF));
		send_cmd(make_cmd(rgbab_pkg::MODE_LOAD, 8, 0, 0, 0, 32'hFF_FF_FF_FF));
		send_cmd(make_cmd(rgbab_pkg::MODE_LOAD, 0, -1, 0, 0, 32'hFF_FF_FF_FF));
		send_cmd(make_draw(0, 0, 16, 12, 0, 0, 0, 0, 1'b1, 8'hFF));
		send_cmd(make_draw(-4, -4, 10, 10, 0, 0, 8, 8, 1'b0, 8'h80));
		send_cmd(make_draw(2, 2, 5, 5, -3, -3, 4, 4, 1'b0, 8'h00));
		send_cmd(make_draw(2, 2, 4, 4, 0, 0, -2, 0, 1'b0, 8'hFF));
		send_cmd(make_draw(2, 2, 4, 4, 20, 20, 4, 4, 1'b0, 8'hFF));
		send_cmd(make_draw(2047, -2048, 3, 3, 0, 0, 3, 3, 1'b0, 8'hFF));
		send_cmd(make_draw(0, 0, 0, 5, 0, 0, 3, 3, 1'b0, 8'hFF));
		send_cmd(make_cmd(rgbab_pkg::MODE_READ, 4, 4, 0, 0, 0));
	endtask

	task automatic test_unknown_modes();
		for (int m = 5; m < 8; m++) send_cmd(make_cmd(3'(m), 1, 1, 2, 2, $urandom));
	endtask

	function automatic int pick_coord(input int span);
		if ($urandom_range(0, 7) == 0) return int'($signed(12'($urandom)));
		return $urandom_range(0, span + 8) - 4;
	endfunction

	// Random commands, mostly well-formed and inside the current sizes.
	task automatic test_random(input int count);
		blit_cmd_t c;
		int        sel, fw, fh, tw, th;
		for (int n = 0; n < count; n++) begin
			fw = eff_size(reg_fb_w, FW_MAX);
			fh = eff_size(reg_fb_h, FH_MAX);
			tw = eff_size(reg_tex_w, TEX_MAX);
			th = eff_size(reg_tex_h, TEX_MAX);
			sel = $urandom_range(0, 99);
			c = make_cmd(rgbab_pkg::MODE_READ, pick_coord(fw), pick_coord(fh),
				$urandom_range(0, 27) - 3, $urandom_range(0, 27) - 3, $urandom);
			if (sel < 25) begin
				c.mode = rgbab_pkg::MODE_LOAD;
				c.dest_x = 12'(pick_coord(tw));
				c.dest_y = 12'(pick_coord(th));
			end else if (sel < 45) begin
				c.mode = rgbab_pkg::MODE_FILL;
			end else if (sel < 70) begin
				c = make_draw(pick_coord(fw), pick_coord(fh), $urandom_range(0, 27) - 3,
					$urandom_range(0, 27) - 3, pick_coord(tw), pick_coord(th),
					$urandom_range(0, 15) - 3, $urandom_range(0, 15) - 3,
					$urandom_range(0, 3) == 0,
					$urandom_range(0, 1) ? 8'hFF : 8'($urandom));
			end else if (sel < 93) begin
				c.mode = rgbab_pkg::MODE_READ;
			end else if (sel < 96) begin
				c.mode = rgbab_pkg::MODE_CLEAR;
			end else begin
				c.mode = 3'($urandom_range(5, 7));
			end
			send_cmd(c);
		end
	endtask

	// The receiver holds off while commands keep coming, so the input stalls.
	task automatic test_backpressure();
		wait_idle();
		hold_rx = 1'b1;
		fork
			begin
				repeat (300) @(negedge clk);
				hold_rx = 1'b0;
			end
			test_random(12);
		join
	endtask

	task automatic test_size_extremes();
		set_sizes(0, 5, 0, 0);
		send_cmd(make_cmd(rgbab_pkg::MODE_LOAD, 0, 0, 0, 0, 32'hC0_01_02_03));
		send_cmd(make_draw(0, 0, 1, 5, 0, 0, 0, 0, 1'b1, 8'hFF));
		send_cmd(make_cmd(rgbab_pkg::MODE_READ, 0, 4, 0, 0, 0));
		set_sizes(1023, 1, 511, 511);
		send_cmd(make_cmd(rgbab_pkg::MODE_LOAD, 255, 255, 0, 0, 32'hFF_9A_BC_DE));
		send_cmd(make_draw(500, 0, 12, 1, 250, 255, 6, 1, 1'b0, 8'hFF));
		send_cmd(make_cmd(rgbab_pkg::MODE_READ, 511, 0, 0, 0, 0));
		test_random(15);
		set_sizes(512, 512, 256, 256);
		send_cmd(make_cmd(rgbab_pkg::MODE_FILL, 509, 509, 8, 8, 32'h90_44_55_66));
		send_cmd(make_draw(508, 508, 4, 4, 0, 0, 0, 0, 1'b1, 8'hFF));
		send_cmd(make_cmd(rgbab_pkg::MODE_READ, 511, 511, 0, 0, 0));
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = rgbab_pkg::REG_FB_WIDTH;
		cfg_data = '0;
		hold_rx = 1'b0;
		rx_done = 1'b0;
		sent_cnt = 0;
		got_cnt = 0;
		mismatch_cnt = 0;
		cur_cmd = make_cmd(rgbab_pkg::MODE_CLEAR, 0, 0, 0, 0, 0);
		reg_fb_w = rgbab_pkg::FB_WIDTH_RST;
		reg_fb_h = rgbab_pkg::FB_HEIGHT_RST;
		reg_tex_w = rgbab_pkg::TEX_WIDTH_RST;
		reg_tex_h = rgbab_pkg::TEX_HEIGHT_RST;
		for (int i = 0; i < FW_MAX * FH_MAX; i++) frame_mem[i] = '0;
		for (int i = 0; i < TEX_MAX * TEX_MAX; i++) texel_mem[i] = '0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		set_sizes(16, 12, 8, 8);
		test_fill_and_read();
		test_texture_draw();
		test_unknown_modes();
		test_random(20);
		test_backpressure();
		set_sizes(23, 9, 13, 5);
		test_random(20);
		test_size_extremes();

		wait_idle();
		if (mismatch_cnt == 0 && pending_resp.size() == 0) begin
			$display("rgba_blitter_fill_blend_top_tb OK");
		end else begin
			$display("rgba_blitter_fill_blend_top_tb NOT OK");
		end
		$finish;
	end

	// Run limit, well beyond the slowest correct run.
	initial begin
		#40000000;
		$display("rgba_blitter_fill_blend_top_tb NOT OK");
		$finish;
	end

endmodule

`default_nettype wire
